FILE: sv/rse_pkg.sv
// Shared types and constants for the RPN stack evaluator.
// No dependencies; imported by rse_div, rpn_stack_evaluator_core and the testbench.
package rse_pkg;

    localparam int RSE_DATA_W      = 32;
    localparam int RSE_CHAR_W      = 8;
    localparam int RSE_STATUS_W    = 3;
    localparam int RSE_STACK_DEPTH = 16;

    localparam logic [RSE_CHAR_W-1:0] RSE_CH_ZERO  = 8'h30;
    localparam logic [RSE_CHAR_W-1:0] RSE_CH_NINE  = 8'h39;
    localparam logic [RSE_CHAR_W-1:0] RSE_CH_PLUS  = 8'h2B;
    localparam logic [RSE_CHAR_W-1:0] RSE_CH_MINUS = 8'h2D;
    localparam logic [RSE_CHAR_W-1:0] RSE_CH_MUL   = 8'h2A;
    localparam logic [RSE_CHAR_W-1:0] RSE_CH_DIV   = 8'h2F;

    localparam logic [RSE_STATUS_W-1:0] RSE_ST_OK        = 3'd0;
    localparam logic [RSE_STATUS_W-1:0] RSE_ST_UNDERFLOW = 3'd1;
    localparam logic [RSE_STATUS_W-1:0] RSE_ST_BADCHAR   = 3'd2;
    localparam logic [RSE_STATUS_W-1:0] RSE_ST_OVERFLOW  = 3'd3;
    localparam logic [RSE_STATUS_W-1:0] RSE_ST_EMPTY     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

FILE: sv/rse_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rse_pkg. A zero divisor yields zero.
module rse_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rse_pkg::RSE_DATA_W-1:0] i_num,
    input  logic [rse_pkg::RSE_DATA_W-1:0] i_den,
    output logic                          o_done,
    output logic [rse_pkg::RSE_DATA_W-1:0] o_quot
);
    import rse_pkg::*;

    localparam int CNT_W = $clog2(RSE_DATA_W);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [RSE_DATA_W-1:0] r_rem, n_rem;
    logic [RSE_DATA_W-1:0] r_quo, n_quo;
    logic [RSE_DATA_W-1:0] r_den, n_den;
    logic                  r_neg, n_neg;
    logic                  r_zero, n_zero;

    logic [RSE_DATA_W:0]   w_shift;
    logic [RSE_DATA_W:0]   w_diff;
    logic                  w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[RSE_DATA_W-1]};
        w_ge    = w_shift >= {1'b0, r_den};
        w_diff  = w_shift - {1'b0, r_den};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        n_zero = r_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num[RSE_DATA_W-1] ? (~i_num + 1'b1) : i_num;
            n_den  = i_den[RSE_DATA_W-1] ? (~i_den + 1'b1) : i_den;
            n_neg  = i_num[RSE_DATA_W-1] ^ i_den[RSE_DATA_W-1];
            n_zero = (i_den == '0);
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[RSE_DATA_W-1:0] : w_shift[RSE_DATA_W-1:0];
            n_quo = {r_quo[RSE_DATA_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(RSE_DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : (r_neg ? (~r_quo + 1'b1) : r_quo);

endmodule

FILE: sv/rpn_stack_evaluator_core.sv
// RPN evaluator: one ASCII character per word; top of stack in a register, rest in a RAM.
// A digit or an ignored/bad character is taken in the idle state; + - * read the RAM, then update in exec.
// / reads the RAM and waits in the divide state on the bit-serial divider (one quotient bit per cycle).
// A word with tlast then passes through the emit state to load the result register; input waits meanwhile,
// longer while the result register is still full. Reset is synchronous and clears the stack
// count, error code and handshake state; the stack RAM is not cleared.
module rpn_stack_evaluator_core #(
    parameter int STACK_DEPTH = rse_pkg::RSE_STACK_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rse_pkg::RSE_CHAR_W-1:0]   s_axis_tdata,  // [7:0] char_code
    input  logic                            s_axis_tlast,  // last_char
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rse_pkg::RSE_DATA_W-1:0]   m_axis_tdata,  // [31:0] result_value
    output logic [rse_pkg::RSE_STATUS_W-1:0] m_axis_tuser   // [2:0] status
);
    import rse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state r_state, n_state;

    logic [CW-1:0]           r_count, n_count;
    logic [RSE_STATUS_W-1:0] r_err, n_err;
    logic [RSE_DATA_W-1:0]   r_top, n_top;
    logic [RSE_CHAR_W-1:0]   r_op, n_op;
    logic                    r_last, n_last;
    logic                    r_out_valid, n_out_valid;
    logic [RSE_DATA_W-1:0]   r_out_data, n_out_data;
    logic [RSE_STATUS_W-1:0] r_out_status, n_out_status;

    logic [RSE_DATA_W-1:0]   r_mem [STACK_DEPTH];
    logic [RSE_DATA_W-1:0]   r_rd_data;
    logic                    w_mem_we, w_mem_re;
    logic [AW-1:0]           w_mem_waddr, w_mem_raddr;

    logic                    w_div_start, w_div_done;
    logic [RSE_DATA_W-1:0]   w_div_quot;

    logic                    w_is_digit, w_is_op, w_full, w_has_two, w_emit_load;
    logic [CW-1:0]           w_cnt_m1, w_cnt_m2;
    logic [RSE_DATA_W-1:0]   w_alu;

    always_comb begin
        w_is_digit  = (s_axis_tdata >= RSE_CH_ZERO) && (s_axis_tdata <= RSE_CH_NINE);
        w_is_op     = (s_axis_tdata == RSE_CH_PLUS) || (s_axis_tdata == RSE_CH_MINUS) ||
                      (s_axis_tdata == RSE_CH_MUL)  || (s_axis_tdata == RSE_CH_DIV);
        w_full      = r_count >= CW'(STACK_DEPTH);
        w_has_two   = r_count >= CW'(2);
        w_cnt_m1    = r_count - CW'(1);
        w_cnt_m2    = r_count - CW'(2);
        w_emit_load = !r_out_valid || m_axis_tready;
        case (r_op)
            RSE_CH_PLUS:  w_alu = r_rd_data + r_top;
            RSE_CH_MINUS: w_alu = r_rd_data - r_top;
            default:      w_alu = r_rd_data * r_top;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (r_err == RSE_ST_OK && !w_is_digit && w_is_op && w_has_two) begin
                        n_state = ST_EXEC;
                    end else if (s_axis_tlast) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EXEC: begin
                if (r_op == RSE_CH_DIV) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_emit_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_count      = r_count;
        n_err        = r_err;
        n_top        = r_top;
        n_op         = r_op;
        n_last       = r_last;
        n_out_valid  = (r_out_valid && m_axis_tready) ? 1'b0 : r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;
        w_mem_waddr  = w_cnt_m1[AW-1:0];
        w_mem_raddr  = w_cnt_m2[AW-1:0];
        w_div_start  = 1'b0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_op   = s_axis_tdata;
                    n_last = s_axis_tlast;
                    if (r_err == RSE_ST_OK) begin
                        if (w_is_digit) begin
                            if (w_full) begin
                                n_err = RSE_ST_OVERFLOW;
                            end else begin
                                w_mem_we = (r_count != '0);
                                n_top    = {{(RSE_DATA_W-4){1'b0}}, s_axis_tdata[3:0]};
                                n_count  = r_count + CW'(1);
                            end
                        end else if (!w_is_op) begin
                            n_err = RSE_ST_BADCHAR;
                        end else if (!w_has_two) begin
                            n_err = RSE_ST_UNDERFLOW;
                        end else begin
                            w_mem_re = 1'b1;
                        end
                    end
                end
            end
            ST_EXEC: begin
                if (r_op == RSE_CH_DIV) begin
                    w_div_start = 1'b1;
                end else begin
                    n_top   = w_alu;
                    n_count = w_cnt_m1;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_top   = w_div_quot;
                    n_count = w_cnt_m1;
                end
            end
            ST_EMIT: begin
                if (w_emit_load) begin
                    n_out_valid = 1'b1;
                    if (r_err != RSE_ST_OK) begin
                        n_out_status = r_err;
                        n_out_data   = '0;
                    end else if (r_count == '0) begin
                        n_out_status = RSE_ST_EMPTY;
                        n_out_data   = '0;
                    end else begin
                        n_out_status = RSE_ST_OK;
                        n_out_data   = r_top;
                    end
                    n_count = '0;
                    n_err   = RSE_ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_err       <= RSE_ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_top        <= n_top;
        r_op         <= n_op;
        r_last       <= n_last;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    // stack RAM: entries below the top, one write and one read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_mem_raddr];
        end
    end

    rse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_rd_data),
        .i_den   (r_top),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside divide state");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_emit_load) |=> (r_count == '0 && r_err == RSE_ST_OK))
        else $error("expression state not cleared after result");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == ST_EMIT)
        else $error("result word raised outside emit");

    a_exec_has_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXEC |-> r_count >= CW'(2))
        else $error("operator executed with fewer than two operands");

endmodule

FILE: test/tb_rpn_stack_evaluator_core.sv
// Self-checking testbench for rpn_stack_evaluator_core: directed and random RPN expressions.
// A scoreboard class predicts each result word; depends on rse_pkg and the core RTL.
module tb_rpn_stack_evaluator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rse_pkg::*;

    typedef struct packed {
        logic [RSE_DATA_W-1:0]   value;
        logic [RSE_STATUS_W-1:0] status;
    } t_rpn_result;

    class rpn_eval_model;
        logic [RSE_DATA_W-1:0]   slots [RSE_STACK_DEPTH];
        int unsigned             depth;
        logic [RSE_STATUS_W-1:0] err;
        t_rpn_result             due_results[$];
        int                      fail_cnt;

        function new();
            depth    = 0;
            err      = RSE_ST_OK;
            fail_cnt = 0;
        endfunction

        function logic [RSE_DATA_W-1:0] quotient(logic [RSE_DATA_W-1:0] num,
                                                 logic [RSE_DATA_W-1:0] den);
            if (den == '0)
                return '0;
            if (num == 32'h8000_0000 && den == '1)
                return num;
            return $signed(num) / $signed(den);
        endfunction

        // Returns 1 when the character was evaluated rather than skipped after an error.
        function bit take_char(logic [RSE_CHAR_W-1:0] c, logic last);
            bit                    evaluated;
            logic [RSE_DATA_W-1:0] s;
            logic [RSE_DATA_W-1:0] t;
            logic [RSE_DATA_W-1:0] r;
            t_rpn_result           res;
            evaluated = (err == RSE_ST_OK);
            if (evaluated) begin
                if (c >= RSE_CH_ZERO && c <= RSE_CH_NINE) begin
                    if (depth >= RSE_STACK_DEPTH) begin
                        err = RSE_ST_OVERFLOW;
                    end else begin
                        slots[depth] = {24'd0, c - RSE_CH_ZERO};
                        depth++;
                    end
                end else if (c == RSE_CH_PLUS || c == RSE_CH_MINUS ||
                             c == RSE_CH_MUL || c == RSE_CH_DIV) begin
                    if (depth < 2) begin
                        err = RSE_ST_UNDERFLOW;
                    end else begin
                        t = slots[depth-1];
                        s = slots[depth-2];
                        case (c)
                            RSE_CH_PLUS:  r = s + t;
                            RSE_CH_MINUS: r = s - t;
                            RSE_CH_MUL:   r = s * t;
                            default:      r = quotient(s, t);
                        endcase
                        depth--;
                        slots[depth-1] = r;
                    end
                end else begin
                    err = RSE_ST_BADCHAR;
                end
            end
            if (last) begin
                res.status = err;
                res.value  = '0;
                if (err == RSE_ST_OK) begin
                    if (depth == 0)
                        res.status = RSE_ST_EMPTY;
                    else
                        res.value = slots[depth-1];
                end
                due_results.push_back(res);
                depth = 0;
                err   = RSE_ST_OK;
            end
            return evaluated;
        endfunction

        function void match_result(logic [RSE_DATA_W-1:0] value,
                                   logic [RSE_STATUS_W-1:0] status);
            t_rpn_result want;
            if (due_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result word: value %0d status %0d",
                             $signed(value), status);
                return;
            end
            want = due_results.pop_front();
            if (want.value !== value || want.status !== status) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                             $signed(want.value), want.status, $signed(value), status);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [RSE_CHAR_W-1:0]   s_axis_tdata;   // [7:0] char_code
    logic                    s_axis_tlast;   // last_char
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [RSE_DATA_W-1:0]   m_axis_tdata;   // [31:0] result_value
    logic [RSE_STATUS_W-1:0] m_axis_tuser;   // [2:0] status

    rpn_eval_model         sb;
    logic [RSE_CHAR_W-1:0] expr_chars[$];
    int unsigned           sent_cnt = 0;
    bit                    no_gaps = 1'b0;
    bit                    hold_go = 1'b0;
    bit                    hold_done = 1'b0;

    rpn_stack_evaluator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [RSE_CHAR_W-1:0] digit_ch(int unsigned d);
        return RSE_CH_ZERO + d[7:0];
    endfunction

    function automatic logic [RSE_CHAR_W-1:0] any_op();
        case ($urandom_range(3))
            0:       return RSE_CH_PLUS;
            1:       return RSE_CH_MINUS;
            2:       return RSE_CH_MUL;
            default: return RSE_CH_DIV;
        endcase
    endfunction

    // Random walk on the stack depth so every operator finds two entries.
    function automatic void add_wellformed(int unsigned len);
        int unsigned depth;
        int unsigned n;
        depth = 0;
        for (n = 0; n < len; n++) begin
            if (depth < 2 || (depth < RSE_STACK_DEPTH && $urandom_range(99) < 50)) begin
                expr_chars.push_back(digit_ch($urandom_range(9)));
                depth++;
            end else begin
                expr_chars.push_back(any_op());
                depth--;
            end
        end
    endfunction

    task automatic send_char(input logic [RSE_CHAR_W-1:0] c, input logic last);
        while (!no_gaps && $urandom_range(99) < 22) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        void'(sb.take_char(c, last));
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic send_expr();
        int unsigned i;
        for (i = 0; i < expr_chars.size(); i++)
            send_char(expr_chars[i], i == expr_chars.size() - 1);
    endtask

    task automatic run_text(input string s);
        int i;
        expr_chars.delete();
        for (i = 0; i < s.len(); i++)
            expr_chars.push_back(s[i]);
        send_expr();
    endtask

    task automatic build_expr();
        int unsigned kind;
        int unsigned len;
        int unsigned pos;
        expr_chars.delete();
        kind = $urandom_range(99);
        len  = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        if (kind < 58) begin
            add_wellformed(len);
        end else if (kind < 70) begin
            add_wellformed(len);
            pos = $urandom_range(expr_chars.size());
            expr_chars.insert(pos, $urandom_range(1) ? any_op() : 8'($urandom_range(255)));
        end else if (kind < 80) begin
            repeat ($urandom_range(1, 5))
                expr_chars.push_back(8'($urandom_range(255)));
        end else if (kind < 90) begin
            repeat (RSE_STACK_DEPTH)
                expr_chars.push_back(digit_ch($urandom_range(9)));
            if ($urandom_range(1)) begin
                expr_chars.push_back(digit_ch($urandom_range(9)));
                repeat ($urandom_range(3))
                    expr_chars.push_back(any_op());
            end else begin
                repeat ($urandom_range(1, RSE_STACK_DEPTH - 1))
                    expr_chars.push_back(any_op());
            end
        end else begin
            // long products that wrap; the first form lands exactly on the most negative value
            if ($urandom_range(1)) begin
                expr_chars.push_back(digit_ch(8));
                repeat (9) begin
                    expr_chars.push_back(digit_ch(8));
                    expr_chars.push_back(RSE_CH_MUL);
                end
                expr_chars.push_back(digit_ch($urandom_range(1) ? 2 : 6));
                expr_chars.push_back(RSE_CH_MUL);
            end else begin
                expr_chars.push_back(digit_ch($urandom_range(2, 9)));
                repeat ($urandom_range(8, 14)) begin
                    expr_chars.push_back(digit_ch($urandom_range(2, 9)));
                    expr_chars.push_back(RSE_CH_MUL);
                end
            end
            if ($urandom_range(1)) begin
                expr_chars.push_back(digit_ch(0));
                expr_chars.push_back(digit_ch(1));
                expr_chars.push_back(RSE_CH_MINUS);
                expr_chars.push_back(RSE_CH_DIV);
            end else begin
                expr_chars.push_back(digit_ch($urandom_range(9)));
                expr_chars.push_back(any_op());
            end
        end
        if (expr_chars.size() == 0)
            expr_chars.push_back(digit_ch($urandom_range(9)));
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready = no_gaps || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.match_result(m_axis_tdata, m_axis_tuser);
    end

    initial begin
        int unsigned exprs;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        run_text("39-4/");
        run_text("80/");
        run_text("67*");
        run_text("5+");
        run_text("+55+");
        run_text("129+");
        run_text("5x");

        exprs = 0;
        while (sent_cnt < 1750) begin
            build_expr();
            send_expr();
            exprs++;
            if (exprs == 40)
                no_gaps = 1'b1;
            if (exprs == 75)
                no_gaps = 1'b0;
            if (exprs == 110)
                hold_go = 1'b1;
        end
        s_axis_tvalid = 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.fail_cnt == 0 && sb.due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: rpn_stack_evaluator_core.f
sv/rse_pkg.sv
sv/rse_div.sv
sv/rpn_stack_evaluator_core.sv
test/tb_rpn_stack_evaluator_core.sv
